// ----- hw/rtl/med_pkg.sv -----
// ----------------------------------------------------------------------------
// med_pkg
// Shared types and constants for the bit-vector edit distance block.
// ----------------------------------------------------------------------------
package med_pkg;

	// Number of word lanes, fixed by the per-lane letter and score fields
	localparam int N_LANES = 8;

	// Configuration port geometry: one 32-bit register at byte address 0
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	typedef logic [4:0]  letter_t;
	typedef logic [3:0]  position_t;
	typedef logic [4:0]  qlen_t;
	typedef logic [15:0] score_t;
	typedef logic [N_LANES-1:0] lane_mask_t;

	// Register index within the configuration space
	typedef enum logic [0:0] {
		REG_QUERY_LENGTH = 1'b0
	} reg_index_t;

	localparam qlen_t QUERY_LENGTH_RESET = 5'd1;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_COLUMN = 1'b1
	} action_t;

	// Per-column control shared by all lanes
	typedef struct packed {
		logic step;     // column transaction accepted this cycle
		logic restart;  // first column of a new comparison
	} lane_ctrl_t;

endpackage

// ----- hw/rtl/med_if.sv -----
// ----------------------------------------------------------------------------
// med_item_if / med_result_if
// Valid/ready channels for column and load items and for score results.
// ----------------------------------------------------------------------------
interface med_item_if;
	import med_pkg::*;

	logic       valid;
	logic       ready;
	action_t    action;
	position_t  position;
	letter_t    letter_0;
	letter_t    letter_1;
	letter_t    letter_2;
	letter_t    letter_3;
	letter_t    letter_4;
	letter_t    letter_5;
	letter_t    letter_6;
	letter_t    letter_7;
	lane_mask_t active_mask;
	logic       last_column;

	modport source (
		output valid, action, position, letter_0, letter_1, letter_2, letter_3,
		       letter_4, letter_5, letter_6, letter_7, active_mask, last_column,
		input  ready
	);
	modport sink (
		input  valid, action, position, letter_0, letter_1, letter_2, letter_3,
		       letter_4, letter_5, letter_6, letter_7, active_mask, last_column,
		output ready
	);
endinterface

interface med_result_if;
	import med_pkg::*;

	logic   valid;
	logic   ready;
	score_t score_0;
	score_t score_1;
	score_t score_2;
	score_t score_3;
	score_t score_4;
	score_t score_5;
	score_t score_6;
	score_t score_7;

	modport source (
		output valid, score_0, score_1, score_2, score_3,
		       score_4, score_5, score_6, score_7,
		input  ready
	);
	modport sink (
		input  valid, score_0, score_1, score_2, score_3,
		       score_4, score_5, score_6, score_7,
		output ready
	);
endinterface

// ----- hw/rtl/med_cfg.sv -----
// ----------------------------------------------------------------------------
// med_cfg
// APB register file holding the query length.
// ----------------------------------------------------------------------------
module med_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [med_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [med_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [med_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output med_pkg::qlen_t                      query_length
);
	import med_pkg::*;

	logic       wr_en;
	reg_index_t reg_sel;
	logic       hit;
	qlen_t      query_length_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:2]);
	assign hit     = (reg_sel == REG_QUERY_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q <= QUERY_LENGTH_RESET;
		end else if (wr_en && hit) begin
			query_length_q <= pwdata[4:0];
		end
	end

	assign prdata       = hit ? APB_DATA_W'(query_length_q) : '0;
	assign query_length = query_length_q;

endmodule

// ----- hw/rtl/med_qbank.sv -----
// ----------------------------------------------------------------------------
// med_qbank
// Query letter sets, one per query position, and per-lane match vectors.
// ----------------------------------------------------------------------------
module med_qbank #(
	parameter int QUERY_MAX     = 16,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_en,
	input  med_pkg::position_t   position,
	input  med_pkg::letter_t     letters [med_pkg::N_LANES],
	output logic [QUERY_MAX-1:0] eq      [med_pkg::N_LANES]
);
	import med_pkg::*;

	// Each position keeps the set of letters loaded there (transposed bitmap)
	logic [ALPHABET_SIZE-1:0] pos_set_q   [QUERY_MAX];
	logic [ALPHABET_SIZE-1:0] pos_set_nxt [QUERY_MAX];
	logic [ALPHABET_SIZE-1:0] hot         [N_LANES];

	// One-hot decode; letters outside the alphabet decode to zero
	always_comb begin
		for (int k = 0; k < N_LANES; k++) begin
			for (int a = 0; a < ALPHABET_SIZE; a++) begin
				hot[k][a] = (int'(letters[k]) == a);
			end
		end
	end

	// Load: position 0 clears every set first, then mark the letter
	always_comb begin
		for (int p = 0; p < QUERY_MAX; p++) begin
			pos_set_nxt[p] = pos_set_q[p];
			if (position == '0) begin
				pos_set_nxt[p] = '0;
			end
			if (int'(position) == p) begin
				pos_set_nxt[p] = pos_set_nxt[p] | hot[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < QUERY_MAX; p++) begin
				pos_set_q[p] <= '0;
			end
		end else if (load_en) begin
			pos_set_q <= pos_set_nxt;
		end
	end

	always_comb begin
		for (int k = 0; k < N_LANES; k++) begin
			for (int p = 0; p < QUERY_MAX; p++) begin
				eq[k][p] = |(pos_set_q[p] & hot[k]);
			end
		end
	end

endmodule

// ----- hw/rtl/med_lane.sv -----
// ----------------------------------------------------------------------------
// med_lane
// One Myers bit-vector column step with vertical vectors and running score.
// ----------------------------------------------------------------------------
module med_lane #(
	parameter int QUERY_MAX = 16,
	parameter int IDX_W     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  med_pkg::lane_ctrl_t  ctrl,
	input  logic                 active,
	input  logic [QUERY_MAX-1:0] eq,
	input  logic [IDX_W-1:0]     top_idx,
	input  med_pkg::score_t      init_score,
	output med_pkg::score_t      score_nxt
);
	import med_pkg::*;

	logic [QUERY_MAX-1:0] vp_q, vn_q;
	score_t               score_q;

	logic [QUERY_MAX-1:0] cur_vp, cur_vn;
	score_t               cur_score;
	logic [QUERY_MAX-1:0] x, sum, d0, hn, hp, y, step_vp, step_vn;
	logic [QUERY_MAX-1:0] vp_nxt, vn_nxt;

	always_comb begin
		// A new comparison starts from the clean column
		cur_vp    = ctrl.restart ? '1 : vp_q;
		cur_vn    = ctrl.restart ? '0 : vn_q;
		cur_score = ctrl.restart ? init_score : score_q;

		x       = eq | cur_vn;
		sum     = (cur_vp & x) + cur_vp;
		d0      = (sum ^ cur_vp) | x;
		hn      = cur_vp & d0;
		hp      = cur_vn | ~(cur_vp | d0);
		y       = {hp[QUERY_MAX-2:0], 1'b1};
		step_vn = y & d0;
		step_vp = {hn[QUERY_MAX-2:0], 1'b0} | ~(y | d0);

		vp_nxt    = cur_vp;
		vn_nxt    = cur_vn;
		score_nxt = cur_score;
		if (active) begin
			vp_nxt = step_vp;
			vn_nxt = step_vn;
			if (hp[top_idx]) begin
				score_nxt = cur_score + score_t'(1);
			end else if (hn[top_idx]) begin
				score_nxt = cur_score - score_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q    <= '1;
			vn_q    <= '0;
			score_q <= '0;
		end else if (ctrl.step) begin
			vp_q    <= vp_nxt;
			vn_q    <= vn_nxt;
			score_q <= score_nxt;
		end
	end

endmodule

// ----- hw/rtl/med_merge.sv -----
// ----------------------------------------------------------------------------
// med_merge
// Collects the lane scores of a finished comparison into the result register.
// ----------------------------------------------------------------------------
module med_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            pop,
	input  med_pkg::score_t score_nxt [med_pkg::N_LANES],
	output logic            valid,
	output med_pkg::score_t scores    [med_pkg::N_LANES]
);
	import med_pkg::*;

	logic   valid_q;
	score_t scores_q [N_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			scores_q <= score_nxt;
		end
	end

	assign valid  = valid_q;
	assign scores = scores_q;

endmodule

// ----- hw/rtl/myers_edit_distance_8lane.sv -----
// ----------------------------------------------------------------------------
// myers_edit_distance_8lane
// Edit distance of one query word against eight words side by side.
// ----------------------------------------------------------------------------
// Usage:
//  - Set query_length over APB (byte address 0), then load the query one
//    letter per transaction on the item channel with action = load; a load
//    at position 0 clears the previously loaded query.
//  - Stream column transactions (action = column): one letter per lane and
//    an active mask. Clear a lane's mask bit once its word has ended.
//  - The column with last_column set closes the comparison; its eight
//    scores appear on the result channel in the cycle after that transaction.
//  - Throughput: one item per cycle, except while a last column stalls.
//    Each lane does its whole column update (one query-wide add plus bit
//    logic) combinationally and registers it on each accepted column.
//  - When the receiver stalls, the result register holds its scores; loads
//    and ordinary columns still flow, and only the next last column waits.
//  - Reset clears the query and the result valid flag, resets the lane
//    vectors and sets query_length to 1; no comparison is open after reset.
// ----------------------------------------------------------------------------
module myers_edit_distance_8lane #(
	parameter int QUERY_MAX     = 16,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic                           clk,
	input  logic                           arst_n,
	med_item_if.sink                       item,
	med_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [med_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [med_pkg::APB_DATA_W-1:0] pwdata,
	output logic [med_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import med_pkg::*;

	localparam int IDX_W = $clog2(QUERY_MAX);
	localparam int LEN_W = $clog2(QUERY_MAX + 1);

	qlen_t                query_length;
	logic [LEN_W-1:0]     eff_len;
	logic [IDX_W-1:0]     top_idx;
	score_t               init_score;

	letter_t              letters   [N_LANES];
	logic [QUERY_MAX-1:0] eq        [N_LANES];
	score_t               score_nxt [N_LANES];
	score_t               scores    [N_LANES];

	logic       accept, load_acc, col_acc, last_acc;
	logic       res_valid;
	logic       open_q;
	lane_ctrl_t lane_ctrl;

	// Configuration registers
	med_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.query_length (query_length)
	);

	// Clamp the query length to 1..QUERY_MAX; its top bit is the scored row
	always_comb begin
		if (query_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(query_length) > QUERY_MAX) begin
			eff_len = LEN_W'(QUERY_MAX);
		end else begin
			eff_len = LEN_W'(query_length);
		end
	end
	assign top_idx    = IDX_W'(eff_len - LEN_W'(1));
	assign init_score = score_t'(eff_len);

	// Handshake: only a last column needs room in the result register
	assign item.ready = !res_valid || result.ready
	                    || !(item.action == ACT_COLUMN && item.last_column);
	assign accept   = item.valid && item.ready;
	assign load_acc = accept && (item.action == ACT_LOAD);
	assign col_acc  = accept && (item.action == ACT_COLUMN);
	assign last_acc = col_acc && item.last_column;

	// Comparison tracking: open on the first column, close on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (col_acc) begin
			open_q <= !item.last_column;
		end
	end

	assign lane_ctrl.step    = col_acc;
	assign lane_ctrl.restart = !open_q;

	assign letters[0] = item.letter_0;
	assign letters[1] = item.letter_1;
	assign letters[2] = item.letter_2;
	assign letters[3] = item.letter_3;
	assign letters[4] = item.letter_4;
	assign letters[5] = item.letter_5;
	assign letters[6] = item.letter_6;
	assign letters[7] = item.letter_7;

	// Query store; loads take their letter from lane 0
	med_qbank #(
		.QUERY_MAX     (QUERY_MAX),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_qbank (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_en  (load_acc),
		.position (item.position),
		.letters  (letters),
		.eq       (eq)
	);

	// One Myers core per lane; inactive lanes hold their state
	for (genvar k = 0; k < N_LANES; k++) begin : g_lane
		med_lane #(
			.QUERY_MAX (QUERY_MAX),
			.IDX_W     (IDX_W)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (lane_ctrl),
			.active     (item.active_mask[k]),
			.eq         (eq[k]),
			.top_idx    (top_idx),
			.init_score (init_score),
			.score_nxt  (score_nxt[k])
		);
	end

	// Capture the finished scores of all lanes
	med_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (last_acc),
		.pop       (result.ready),
		.score_nxt (score_nxt),
		.valid     (res_valid),
		.scores    (scores)
	);

	assign result.valid   = res_valid;
	assign result.score_0 = scores[0];
	assign result.score_1 = scores[1];
	assign result.score_2 = scores[2];
	assign result.score_3 = scores[3];
	assign result.score_4 = scores[4];
	assign result.score_5 = scores[5];
	assign result.score_6 = scores[6];
	assign result.score_7 = scores[7];

	// A new result only follows an accepted last column
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(last_acc))
		else $error("result valid without a last column");

	// The last column always closes the comparison
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		last_acc |=> !open_q)
		else $error("comparison still open after last column");

	// Loads never change the comparison state
	a_load_keeps_open: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> $stable(open_q))
		else $error("load changed comparison state");

	// Input stalls only when a held result blocks a last column
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (res_valid && !result.ready))
		else $error("input stalled without a pending result");

endmodule

// ----- dv/tb_myers_edit_distance_8lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_myers_edit_distance_8lane
// Self-checking bench for the eight-lane bit-vector edit distance block.
// Queued load and column transactions are driven with random gaps on the
// item channel. A local lane model predicts the eight scores of every closed
// comparison, and each score transaction is checked field by field in
// arrival order. The query length register is swept over APB between phases.
// ----------------------------------------------------------------------------
module tb_myers_edit_distance_8lane;
	import med_pkg::*;

	localparam int QMAX         = 16;
	localparam int ALPHA        = 26;
	localparam int RAND_ITEMS   = 1750;
	localparam int CALM_FROM    = 1500;    // no idling on either side past this
	localparam int LONG_HOLD    = 400;     // receiver hold-off that backs up the block
	localparam int HOLD_AT      = 30;      // score transactions seen before that hold-off
	localparam int HOLD_BACKLOG = 40;      // queued transactions that keep the sender busy
	localparam int SETTLE       = 4;       // settling margin after a drain
	localparam int unsigned CYCLE_LIMIT = 300000;

	// One transaction of the item channel
	typedef struct packed {
		action_t         action;
		position_t       position;
		letter_t [7:0]   letters;
		lane_mask_t      mask;
		logic            last;
	} med_item_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	med_item_if   item_ch ();
	med_result_if result_ch ();

	myers_edit_distance_8lane u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Lane model: match bitmap, per-lane vertical vectors and running scores
	// ------------------------------------------------------------------------
	logic [QMAX-1:0] letter_bits [ALPHA];
	logic [QMAX-1:0] vpos [N_LANES];
	logic [QMAX-1:0] vneg [N_LANES];
	score_t          lane_dist [N_LANES];
	bit              cmp_open;
	qlen_t           qlen_cfg;

	score_t [7:0] pending_scores [$];   // scores owed by closed comparisons
	med_item_t    queued_items [$];     // transactions not yet offered
	int           items_queued;
	int           items_accepted;
	int           fails;

	// Stimulus knobs; idle_pct and quiet are shared by both sides of the handshake
	int  idle_pct;
	bit  quiet;
	int  alpha_base;
	int  alpha_span;
	letter_t query_word [QMAX];

	// Advance the model by one accepted transaction; queue scores on a last column
	function automatic void edit_distance_step(med_item_t it);
		logic [QMAX-1:0] eq, x, d0, hn, hp, y, vp, vn, top;
		int unsigned     eff;
		score_t [7:0]    row;
		if (it.action == ACT_LOAD) begin
			// position 0 starts a fresh query
			if (it.position == '0)
				foreach (letter_bits[i]) letter_bits[i] = '0;
			// out-of-alphabet letters set nothing
			if (it.letters[0] < ALPHA)
				letter_bits[it.letters[0]][it.position] = 1'b1;
			return;
		end
		// clamp the query length: 0 behaves as 1, above QMAX as QMAX
		eff = (qlen_cfg == '0) ? 1 : (qlen_cfg > QMAX) ? QMAX : qlen_cfg;
		if (!cmp_open) begin
			for (int k = 0; k < N_LANES; k++) begin
				vpos[k]      = '1;
				vneg[k]      = '0;
				lane_dist[k] = score_t'(eff);
			end
			cmp_open = 1'b1;
		end
		top = QMAX'(1) << (eff - 1);
		for (int k = 0; k < N_LANES; k++) begin
			// inactive lanes hold vectors and score
			if (it.mask[k]) begin
				eq = (it.letters[k] < ALPHA) ? letter_bits[it.letters[k]] : '0;
				vp = vpos[k];
				vn = vneg[k];
				x  = eq | vn;
				d0 = (((vp & x) + vp) ^ vp) | x;
				hn = vp & d0;
				hp = vn | ~(vp | d0);
				y  = (hp << 1) | QMAX'(1);
				vneg[k] = y & d0;
				vpos[k] = (hn << 1) | ~(y | d0);
				// score moves at the query's last bit, wrapping at 16 bits
				if ((hp & top) != '0)
					lane_dist[k] = lane_dist[k] + 1'b1;
				else if ((hn & top) != '0)
					lane_dist[k] = lane_dist[k] - 1'b1;
			end
		end
		if (it.last) begin
			for (int k = 0; k < N_LANES; k++)
				row[k] = lane_dist[k];
			pending_scores.push_back(row);
			cmp_open = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Item driver: pop queued transactions, insert idle bursts, feed the model
	// ------------------------------------------------------------------------
	med_item_t offered;
	int        send_gap;

	always @(posedge clk or negedge arst_n) begin : item_driver
		med_item_t nxt;
		if (!arst_n) begin
			item_ch.valid       <= 1'b0;
			item_ch.action      <= ACT_LOAD;
			item_ch.position    <= '0;
			item_ch.letter_0    <= '0;
			item_ch.letter_1    <= '0;
			item_ch.letter_2    <= '0;
			item_ch.letter_3    <= '0;
			item_ch.letter_4    <= '0;
			item_ch.letter_5    <= '0;
			item_ch.letter_6    <= '0;
			item_ch.letter_7    <= '0;
			item_ch.active_mask <= '0;
			item_ch.last_column <= 1'b0;
			send_gap            <= 0;
			items_accepted = 0;
			cmp_open       = 1'b0;
			foreach (letter_bits[i]) letter_bits[i] = '0;
			for (int k = 0; k < N_LANES; k++) begin
				vpos[k]      = '1;
				vneg[k]      = '0;
				lane_dist[k] = '0;
			end
		end else begin
			// a transaction moved at this edge: predict what it causes
			if (item_ch.valid && item_ch.ready) begin
				edit_distance_step(offered);
				items_accepted++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					item_ch.valid <= 1'b0;
				end else if (queued_items.size() > 0 && !quiet &&
					     $urandom_range(99) < idle_pct) begin
					// idle burst: drop valid and set a random gap
					send_gap      <= $urandom_range(3);
					item_ch.valid <= 1'b0;
				end else if (queued_items.size() > 0) begin
					nxt = queued_items.pop_front();
					offered              <= nxt;
					item_ch.valid        <= 1'b1;
					item_ch.action       <= nxt.action;
					item_ch.position     <= nxt.position;
					item_ch.letter_0     <= nxt.letters[0];
					item_ch.letter_1     <= nxt.letters[1];
					item_ch.letter_2     <= nxt.letters[2];
					item_ch.letter_3     <= nxt.letters[3];
					item_ch.letter_4     <= nxt.letters[4];
					item_ch.letter_5     <= nxt.letters[5];
					item_ch.letter_6     <= nxt.letters[6];
					item_ch.letter_7     <= nxt.letters[7];
					item_ch.active_mask  <= nxt.mask;
					item_ch.last_column  <= nxt.last;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Score monitor: random stalls, one long hold-off, field-by-field check
	// ------------------------------------------------------------------------
	int take_gap;
	int hold_left;
	int results_seen;
	bit held_once;

	// Long receiver hold-off; start it while plenty of transactions are queued
	always @(posedge clk or negedge arst_n) begin : hold_timer
		if (!arst_n) begin
			hold_left <= 0;
			held_once <= 1'b0;
		end else if (!held_once && results_seen >= HOLD_AT &&
			     queued_items.size() >= HOLD_BACKLOG) begin
			held_once <= 1'b1;
			hold_left <= LONG_HOLD;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : score_monitor
		score_t [7:0] got;
		score_t [7:0] want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			take_gap        <= 0;
			results_seen    <= 0;
			fails = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.score_7, result_ch.score_6, result_ch.score_5,
				       result_ch.score_4, result_ch.score_3, result_ch.score_2,
				       result_ch.score_1, result_ch.score_0};
				results_seen <= results_seen + 1;
				if (pending_scores.size() == 0) begin
					$error("score transaction with no comparison closed");
					fails++;
				end else begin
					want = pending_scores.pop_front();
					for (int k = 0; k < N_LANES; k++)
						if (got[k] !== want[k]) begin
							$error("score_%0d: expected %0d, actual %0d",
							       k, want[k], got[k]);
							fails++;
						end
				end
			end
			// hold off long enough that the next last column backs up the input
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap        <= take_gap - 1;
				result_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(99) < idle_pct) begin
				take_gap        <= $urandom_range(3);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Drop the run if it hangs
	int unsigned cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic write_query_length(input qlen_t value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(int'(REG_QUERY_LENGTH) << 2);
		// junk above the field must be ignored
		pwdata  <= ($urandom() & ~32'h1F) | APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		qlen_cfg = value;
	endtask

	// Wait until every queued transaction is taken and every score has arrived
	task automatic drain_and_settle();
		while (items_accepted != items_queued || pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_load(input position_t pos, input letter_t ltr);
		med_item_t it;
		it.action   = ACT_LOAD;
		it.position = pos;
		// lane letters, mask and last are don't-care on loads: randomize them
		for (int k = 0; k < N_LANES; k++)
			it.letters[k] = letter_t'($urandom_range(31));
		it.letters[0] = ltr;
		it.mask       = lane_mask_t'($urandom_range(255));
		it.last       = 1'($urandom_range(1));
		queued_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_column(input letter_t [7:0] ltrs, input lane_mask_t m,
				    input logic last);
		med_item_t it;
		it.action   = ACT_COLUMN;
		it.position = position_t'($urandom_range(15));
		it.letters  = ltrs;
		it.mask     = m;
		it.last     = last;
		queued_items.push_back(it);
		items_queued++;
	endtask

	function automatic letter_t alphabet_letter();
		return letter_t'(alpha_base + $urandom_range(alpha_span));
	endfunction

	// Mostly letters near the same query position, so lanes score low
	function automatic letter_t word_letter(int col);
		int r;
		int idx;
		r = $urandom_range(99);
		if (r < 55) begin
			idx = col + $urandom_range(2) - 1;
			idx = (idx < 0) ? 0 : (idx > QMAX - 1) ? QMAX - 1 : idx;
			return query_word[idx];
		end
		if (r < 95)
			return alphabet_letter();
		return letter_t'($urandom_range(26, 31));
	endfunction

	// Eight words of random length, one column per letter, last column closes
	task automatic queue_comparison(input int max_len);
		int            len [N_LANES];
		int            cols;
		letter_t [7:0] ltrs;
		lane_mask_t    m;
		cols = 1;
		for (int k = 0; k < N_LANES; k++) begin
			len[k] = $urandom_range(max_len);
			if (len[k] > cols)
				cols = len[k];
		end
		for (int c = 0; c < cols; c++) begin
			for (int k = 0; k < N_LANES; k++) begin
				m[k]    = (c < len[k]);
				ltrs[k] = m[k] ? word_letter(c) : letter_t'($urandom_range(31));
			end
			// break the prefix shape of the mask now and then
			if ($urandom_range(19) == 0)
				m[$urandom_range(7)] ^= 1'b1;
			// reload a query letter in the middle of a comparison
			if ($urandom_range(29) == 0)
				queue_load(position_t'($urandom_range(15)), alphabet_letter());
			queue_column(ltrs, m, c == cols - 1);
		end
	endtask

	task automatic run_phase();
		int    r;
		int    eff;
		int    n;
		int    cap;
		qlen_t q;
		letter_t ltr;
		r = $urandom_range(19);
		if (r == 0)
			q = '0;
		else if (r == 1)
			q = qlen_t'($urandom_range(QMAX + 1, 31));
		else if (r == 2)
			q = qlen_t'(QMAX);
		else if (r == 3)
			q = qlen_t'(1);
		else
			q = qlen_t'($urandom_range(2, QMAX - 1));
		drain_and_settle();
		write_query_length(q);
		if (!quiet)
			case ($urandom_range(2))
				0: idle_pct <= 0;
				1: idle_pct <= 15;
				default: idle_pct <= 40;
			endcase
		if ($urandom_range(3) == 0) begin
			alpha_base = 0;
			alpha_span = ALPHA - 1;
		end else begin
			alpha_base = $urandom_range(ALPHA - 4);
			alpha_span = 3;
		end
		eff = (q == '0) ? 1 : (q > QMAX) ? QMAX : q;
		// usually the query fills the scored length, sometimes it does not
		n = ($urandom_range(6) == 0) ? $urandom_range(1, QMAX) : eff;
		for (int p = 0; p < n; p++) begin
			ltr = alphabet_letter();
			query_word[p] = ltr;
			queue_load(position_t'(p), ltr);
		end
		cap = (eff + 4 > 20) ? 20 : eff + 4;
		repeat ($urandom_range(4, 10))
			queue_comparison($urandom_range(cap));
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		items_queued   = 0;
		idle_pct       = 15;
		quiet          = 1'b0;
		alpha_base     = 0;
		alpha_span     = ALPHA - 1;
		qlen_cfg       = QUERY_LENGTH_RESET;
		foreach (query_word[i]) query_word[i] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset query length: one-letter query 'a', mixed and out-of-range letters
		queue_load(position_t'(0), letter_t'(0));
		queue_column({5'd31, 5'd25, 5'd0, 5'd25, 5'd0, 5'd26, 5'd0, 5'd25},
			     8'hFF, 1'b1);
		// all lanes inactive: every score stays at the starting length
		queue_column({8{5'd31}}, 8'h00, 1'b1);
		drain_and_settle();

		// Length 0 acts as 1
		write_query_length(qlen_t'(0));
		queue_column('0, 8'h55, 1'b0);
		queue_column({8{5'd25}}, 8'hFF, 1'b1);
		drain_and_settle();

		// Length above the maximum acts as the maximum; edge positions and
		// letters, an ignored letter, and a reload in the middle of a comparison
		write_query_length(qlen_t'(31));
		queue_load(position_t'(0), letter_t'(25));
		queue_load(position_t'(15), letter_t'(0));
		queue_load(position_t'(7), letter_t'(31));
		queue_column({8{5'd25}}, 8'hFF, 1'b0);
		queue_load(position_t'(3), letter_t'(2));
		queue_column({5'd2, 5'd0, 5'd2, 5'd0, 5'd2, 5'd0, 5'd2, 5'd0}, 8'hAA, 1'b0);
		queue_column({5'd0, 5'd25, 5'd2, 5'd30, 5'd0, 5'd25, 5'd2, 5'd0},
			     8'hFF, 1'b1);
		// load at position 0 with a bad letter: clears and sets nothing
		queue_load(position_t'(0), letter_t'(27));
		queue_column({8{5'd25}}, 8'hFF, 1'b1);

		// Random phases, then a final stretch with no idling
		while (items_queued < CALM_FROM)
			run_phase();
		quiet    <= 1'b1;
		idle_pct <= 0;
		while (items_queued < RAND_ITEMS)
			run_phase();

		drain_and_settle();
		repeat (10) @(posedge clk);
		if (fails == 0 && pending_scores.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/med_pkg.sv
hw/rtl/med_if.sv
hw/rtl/med_cfg.sv
hw/rtl/med_qbank.sv
hw/rtl/med_lane.sv
hw/rtl/med_merge.sv
hw/rtl/myers_edit_distance_8lane.sv
dv/tb_myers_edit_distance_8lane.sv
